// ===== design/gcf_pkg.sv =====
// ----------------------------------------------------------------------------
// gcf_pkg: shared constants, types and helpers of the 3x3 gray filter
// Sizes, register map, result tag and the small arithmetic helpers.
// ----------------------------------------------------------------------------
package gcf_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W  = 8;
  localparam int DIM_W  = 13;
  localparam int KROW_W = 36;
  localparam int COEF_W = 12;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int SZ_W  = (DIM_W > POS_W + 1) ? DIM_W : POS_W + 1;

  // product, row sum and total sum widths of the filter datapath
  localparam int PROD_W = PIX_W + 1 + COEF_W;
  localparam int RSUM_W = PROD_W + 2;
  localparam int SUM_W  = RSUM_W + 2;

  // result queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  // APB register map, 8-byte stride
  localparam int APB_DW = 64;
  localparam int APB_AW = 6;
  localparam logic [2:0] REG_KTOP   = 3'd0;
  localparam logic [2:0] REG_KMID   = 3'd1;
  localparam logic [2:0] REG_KBOT   = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  typedef logic [8:0][PIX_W-1:0] taps_t;

  typedef struct packed {
    logic valid;
    logic end_of_row;
    logic end_of_image;
    logic last_of_run;
  } res_meta_t;

  // zero reads as one, anything above the limit saturates
  function automatic logic [SZ_W-1:0] eff_size(input logic [DIM_W-1:0] v,
                                                input logic [SZ_W-1:0] lim);
    logic [SZ_W-1:0] ve;
    ve = SZ_W'(v);
    if (v == '0) return SZ_W'(1);
    else if (ve > lim) return lim;
    else return ve;
  endfunction

  // (77R + 151G + 28B) >> 8
  function automatic logic [PIX_W-1:0] rgb_to_gray(input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b);
    logic [15:0] acc;
    acc = 16'(r) * 16'd77 + 16'(g) * 16'd151 + 16'(b) * 16'd28;
    return acc[15:8];
  endfunction

endpackage

// ===== design/gcf_ram.sv =====
// ----------------------------------------------------------------------------
// gcf_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module gcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/gcf_conv.sv =====
// ----------------------------------------------------------------------------
// gcf_conv: 3x3 multiply-accumulate pipeline with clamp
// Nine tap products, three row sums, then total, shift and clamp to 0..255.
// ----------------------------------------------------------------------------
module gcf_conv (
  input  logic                      clk,
  input  logic                      rst,
  input  gcf_pkg::taps_t            taps,
  input  gcf_pkg::res_meta_t        in_meta,
  input  logic [gcf_pkg::KROW_W-1:0] kernel_top,
  input  logic [gcf_pkg::KROW_W-1:0] kernel_mid,
  input  logic [gcf_pkg::KROW_W-1:0] kernel_bot,
  output logic [gcf_pkg::PIX_W-1:0] pixel,
  output gcf_pkg::res_meta_t        out_meta
);

  logic [2:0][gcf_pkg::KROW_W-1:0]  krows;
  logic signed [gcf_pkg::PROD_W-1:0] prod [9];
  logic signed [gcf_pkg::RSUM_W-1:0] rsum [3];
  logic signed [gcf_pkg::SUM_W-1:0]  total;
  gcf_pkg::res_meta_t               meta_p;

  assign krows = {kernel_bot, kernel_mid, kernel_top};

  // stage 1: products, coefficient for column c sits at bits 12c+11..12c
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[3*r+c] <= $signed({1'b0, taps[3*r+c]})
                     * $signed(krows[r][gcf_pkg::COEF_W*c +: gcf_pkg::COEF_W]);
      end
    end
  end

  // stage 2: row sums
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      rsum[r] <= gcf_pkg::RSUM_W'(prod[3*r]) + gcf_pkg::RSUM_W'(prod[3*r+1])
               + gcf_pkg::RSUM_W'(prod[3*r+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_p   <= '0;
      out_meta <= '0;
    end else begin
      meta_p   <= in_meta;
      out_meta <= meta_p;
    end
  end

  // total, then clamp: negative -> 0, above 255 after the shift -> 255
  always_comb begin
    total = gcf_pkg::SUM_W'(rsum[0]) + gcf_pkg::SUM_W'(rsum[1])
          + gcf_pkg::SUM_W'(rsum[2]);
    if (total[gcf_pkg::SUM_W-1]) begin
      pixel = '0;
    end else if (|total[gcf_pkg::SUM_W-2:gcf_pkg::PIX_W+8]) begin
      pixel = '1;
    end else begin
      pixel = total[gcf_pkg::PIX_W+7:8];
    end
  end

endmodule

// ===== design/gray_conv3x3_filter.sv =====
// ----------------------------------------------------------------------------
// gray_conv3x3_filter: streaming 3x3 convolution on a grayscale image
// RGB pixels in raster order in, clamped filtered gray pixels out.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel (pix_valid/pix_stall, red/green/blue): one RGB pixel per
//   transaction in raster order. Each pixel is turned to gray and a 3x3
//   kernel of signed Q4.8 coefficients is applied; neighbors outside the
//   image take the center value. Results (res_valid/res_stall) leave in
//   raster order as soon as their neighborhood is in: normally one per input,
//   two at the end of a row and on the last row, four on the last pixel.
//   Throughput: an input with several results holds the pixel channel
//   while its extra results issue, as the datapath makes one result per
//   cycle while credits are free; inside an image that is one pixel per
//   clock with credits free, except at the right edge and on the last row.
//   Path: a result passes the line RAM read, tap select, product, row sum
//   and queue registers after the transaction of the pixel that completes
//   its neighborhood.
//   Stall: an 8-entry result queue, with credits counted at issue, absorbs
//   the pipeline; pix_stall rises when all credits are out or while busy.
//   Reset: positions, window, kernel and size registers go to their reset
//   values. The line RAM is not cleared: a row reads entries the row above
//   wrote unless the width grows mid-image. The user must write kernel and
//   size over APB (8-byte stride) only while idle; the block does not check.
// ----------------------------------------------------------------------------
module gray_conv3x3_filter (
  input  logic                        clk,
  input  logic                        rst,
  // pixel channel
  input  logic                        pix_valid,
  output logic                        pix_stall,
  input  logic [7:0]                  red,
  input  logic [7:0]                  green,
  input  logic [7:0]                  blue,
  // result channel
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [7:0]                  filtered_pixel,
  output logic                        end_of_row,
  output logic                        end_of_image,
  output logic                        last_of_run,
  // APB config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gcf_pkg::APB_AW-1:0]  paddr,
  input  logic [gcf_pkg::APB_DW-1:0]  pwdata,
  output logic [gcf_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int PW = gcf_pkg::PIX_W;
  localparam int CW = gcf_pkg::COL_W;
  localparam int RW = gcf_pkg::ROW_W;
  localparam int SW = gcf_pkg::SZ_W;

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [gcf_pkg::KROW_W-1:0] kernel_top, kernel_mid, kernel_bot;
  logic [gcf_pkg::DIM_W-1:0]  image_width, image_height;
  logic [2:0]                 cfg_idx;
  logic                       cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[5:3];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_top   <= '0;
      kernel_mid   <= gcf_pkg::KROW_W'(36'h100000);
      kernel_bot   <= '0;
      image_width  <= gcf_pkg::DIM_W'(640);
      image_height <= gcf_pkg::DIM_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        gcf_pkg::REG_KTOP:   kernel_top   <= pwdata[gcf_pkg::KROW_W-1:0];
        gcf_pkg::REG_KMID:   kernel_mid   <= pwdata[gcf_pkg::KROW_W-1:0];
        gcf_pkg::REG_KBOT:   kernel_bot   <= pwdata[gcf_pkg::KROW_W-1:0];
        gcf_pkg::REG_WIDTH:  image_width  <= pwdata[gcf_pkg::DIM_W-1:0];
        gcf_pkg::REG_HEIGHT: image_height <= pwdata[gcf_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      gcf_pkg::REG_KTOP:   prdata = gcf_pkg::APB_DW'(kernel_top);
      gcf_pkg::REG_KMID:   prdata = gcf_pkg::APB_DW'(kernel_mid);
      gcf_pkg::REG_KBOT:   prdata = gcf_pkg::APB_DW'(kernel_bot);
      gcf_pkg::REG_WIDTH:  prdata = gcf_pkg::APB_DW'(image_width);
      gcf_pkg::REG_HEIGHT: prdata = gcf_pkg::APB_DW'(image_height);
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input position, wrapped against the current size before use
  // --------------------------------------------------------------------------
  logic [SW-1:0] w_eff, h_eff, col_ext, row_ext;
  logic [CW-1:0] in_col, cur_col, col_next;
  logic [RW-1:0] in_row, cur_row, row_next;
  logic          col_end, row_end;
  logic          c0, c1, r0, r1, nr2, nc2, has_out;

  assign w_eff = gcf_pkg::eff_size(image_width, SW'(gcf_pkg::MAX_WIDTH));
  assign h_eff = gcf_pkg::eff_size(image_height, SW'(gcf_pkg::MAX_HEIGHT));

  always_comb begin
    col_ext = SW'(in_col);
    row_ext = SW'(in_row);
    if (col_ext >= w_eff) begin
      col_ext = '0;
      row_ext = row_ext + SW'(1);
    end
    if (row_ext >= h_eff) begin
      row_ext = '0;
    end
    cur_col = col_ext[CW-1:0];
    cur_row = row_ext[RW-1:0];
    col_end = (col_ext == w_eff - SW'(1));
    row_end = (row_ext == h_eff - SW'(1));
    if (col_end) begin
      col_next = '0;
      row_next = row_end ? '0 : cur_row + RW'(1);
    end else begin
      col_next = cur_col + CW'(1);
      row_next = cur_row;
    end
    c0 = (cur_col == '0);
    c1 = (cur_col == CW'(1));
    r0 = (cur_row == '0);
    r1 = (cur_row == RW'(1));
    // results come for rows {r-1 if r>0, r if last row} x same for columns
    nr2     = !r0 && row_end;
    nc2     = !c0 && col_end;
    has_out = (!r0 || row_end) && (!c0 || col_end);
  end

  // --------------------------------------------------------------------------
  // Issue: one slot per cycle when credits allow, own slot then extra results
  // --------------------------------------------------------------------------
  logic               busy;
  logic               job_r0, job_r1, job_c0, job_c1, job_nr2, job_nc2;
  logic               job_i, job_j;
  logic [gcf_pkg::CNT_W-1:0] pending;
  logic               credit_full, acc, extra_go, slot_go, slot_out;
  logic               sl_r0, sl_r1, sl_c0, sl_c1, sl_nr2, sl_nc2, sl_i, sl_j;
  logic               sl_ar2, sl_ac2, sl_top, sl_left, sl_last;
  logic               issue_out, res_acc;
  logic [PW-1:0]      gray;

  assign credit_full = (pending == gcf_pkg::CNT_W'(gcf_pkg::OUT_DEPTH));
  assign pix_stall   = busy || credit_full;
  assign acc         = pix_valid && !pix_stall;
  assign extra_go    = busy && !credit_full;
  assign slot_go     = acc || extra_go;
  assign gray        = gcf_pkg::rgb_to_gray(red, green, blue);

  always_comb begin
    sl_r0  = busy ? job_r0  : r0;
    sl_r1  = busy ? job_r1  : r1;
    sl_c0  = busy ? job_c0  : c0;
    sl_c1  = busy ? job_c1  : c1;
    sl_nr2 = busy ? job_nr2 : nr2;
    sl_nc2 = busy ? job_nc2 : nc2;
    sl_i   = busy ? job_i   : 1'b0;
    sl_j   = busy ? job_j   : 1'b0;
    slot_out = busy || has_out;
    // center row / column of the window: 2 = current, 1 = one back
    sl_ar2  = sl_i || sl_r0;
    sl_ac2  = sl_j || sl_c0;
    sl_top  = sl_ar2 ? sl_r0 : sl_r1;
    sl_left = sl_ac2 ? sl_c0 : sl_c1;
    sl_last = (sl_i == sl_nr2) && (sl_j == sl_nc2);
    issue_out = slot_go && slot_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      busy    <= 1'b0;
      job_i   <= 1'b0;
      job_j   <= 1'b0;
      pending <= '0;
    end else begin
      if (acc) begin
        in_col <= col_next;
        in_row <= row_next;
      end
      if (issue_out) begin
        busy <= !sl_last;
        if (sl_j == sl_nc2) begin
          job_i <= 1'b1;
          job_j <= 1'b0;
        end else begin
          job_i <= sl_i;
          job_j <= 1'b1;
        end
      end
      pending <= pending + gcf_pkg::CNT_W'(issue_out) - gcf_pkg::CNT_W'(res_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      job_r0  <= r0;
      job_r1  <= r1;
      job_c0  <= c0;
      job_c1  <= c1;
      job_nr2 <= nr2;
      job_nc2 <= nc2;
    end
  end

  // --------------------------------------------------------------------------
  // Slot stage: line RAM read-modify-write, window shift, tap select
  // --------------------------------------------------------------------------
  logic          s1_item, s1_out;
  logic          s1_ar2, s1_ac2, s1_top, s1_left, s1_last;
  logic [PW-1:0] s1_gray;
  logic [CW-1:0] s1_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_item <= 1'b0;
      s1_out  <= 1'b0;
    end else begin
      s1_item <= acc;
      s1_out  <= issue_out;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_go) begin
      s1_ar2  <= sl_ar2;
      s1_ac2  <= sl_ac2;
      s1_top  <= sl_top;
      s1_left <= sl_left;
      s1_last <= sl_last;
    end
    if (acc) begin
      s1_gray <= gray;
      s1_col  <= cur_col;
    end
  end

  // line RAM entry: {upper row, middle row}
  logic [2*PW-1:0] ram_q, line_q, wr_data, fwd_data;
  logic [CW-1:0]   fwd_col;
  logic            fwd_valid;

  gcf_ram #(
    .WIDTH (2 * PW),
    .DEPTH (gcf_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_item),
    .waddr (s1_col),
    .wdata (wr_data),
    .raddr (cur_col),
    .rdata (ram_q)
  );

  // a write in the same cycle as the next read (width of one) is forwarded
  assign line_q  = (fwd_valid && fwd_col == s1_col) ? fwd_data : ram_q;
  assign wr_data = {line_q[PW-1:0], s1_gray};

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= s1_item;
    end
    fwd_col  <= s1_col;
    fwd_data <= wr_data;
  end

  // window [row][col]: row 2 = current image row, col 2 = newest column
  logic [2:0][2:0][PW-1:0] win, win_eff;

  always_comb begin
    win_eff = win;
    if (s1_item) begin
      for (int a = 0; a < 3; a++) begin
        win_eff[a][0] = win[a][1];
        win_eff[a][1] = win[a][2];
      end
      win_eff[0][2] = line_q[2*PW-1:PW];
      win_eff[1][2] = line_q[PW-1:0];
      win_eff[2][2] = s1_gray;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_item) begin
      win <= win_eff;
    end
  end

  gcf_pkg::taps_t     taps_d, taps_q;
  gcf_pkg::res_meta_t meta_q;

  always_comb begin
    logic [1:0]    ar, ac, ri, ci;
    logic [PW-1:0] center;
    logic          excl;
    ar     = s1_ar2 ? 2'd2 : 2'd1;
    ac     = s1_ac2 ? 2'd2 : 2'd1;
    center = win_eff[ar][ac];
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        ri = s1_ar2 ? ((k == 2) ? 2'd2 : 2'(k + 1)) : 2'(k);
        ci = s1_ac2 ? ((m == 2) ? 2'd2 : 2'(m + 1)) : 2'(m);
        // off-image neighbors take the center value
        excl = (k == 0 && s1_top) || (k == 2 && s1_ar2)
            || (m == 0 && s1_left) || (m == 2 && s1_ac2);
        taps_d[3*k+m] = excl ? center : win_eff[ri][ci];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_q <= '0;
    end else begin
      meta_q.valid        <= s1_out;
      meta_q.end_of_row   <= s1_ac2;
      meta_q.end_of_image <= s1_ac2 && s1_ar2;
      meta_q.last_of_run  <= s1_last;
    end
    taps_q <= taps_d;
  end

  // --------------------------------------------------------------------------
  // Filter datapath
  // --------------------------------------------------------------------------
  logic [PW-1:0]      conv_pixel;
  gcf_pkg::res_meta_t conv_meta;

  gcf_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .taps       (taps_q),
    .in_meta    (meta_q),
    .kernel_top (kernel_top),
    .kernel_mid (kernel_mid),
    .kernel_bot (kernel_bot),
    .pixel      (conv_pixel),
    .out_meta   (conv_meta)
  );

  // --------------------------------------------------------------------------
  // Result queue; credits at issue keep it from overflowing
  // --------------------------------------------------------------------------
  logic [gcf_pkg::OUT_DEPTH-1:0][PW+2:0] q_mem;
  logic [gcf_pkg::OUT_AW-1:0]            wr_ptr, rd_ptr;
  logic [gcf_pkg::CNT_W-1:0]             q_cnt;
  logic                                  q_push;

  assign q_push    = conv_meta.valid;
  assign res_valid = (q_cnt != '0);
  assign res_acc   = res_valid && !res_stall;
  assign {filtered_pixel, end_of_row, end_of_image, last_of_run} = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= (wr_ptr == gcf_pkg::OUT_AW'(gcf_pkg::OUT_DEPTH - 1))
                  ? '0 : wr_ptr + gcf_pkg::OUT_AW'(1);
      end
      if (res_acc) begin
        rd_ptr <= (rd_ptr == gcf_pkg::OUT_AW'(gcf_pkg::OUT_DEPTH - 1))
                  ? '0 : rd_ptr + gcf_pkg::OUT_AW'(1);
      end
      q_cnt <= q_cnt + gcf_pkg::CNT_W'(q_push) - gcf_pkg::CNT_W'(res_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[wr_ptr] <= {conv_pixel, conv_meta.end_of_row, conv_meta.end_of_image,
                        conv_meta.last_of_run};
    end
  end

endmodule

// ===== design/gcf_checker.sv =====
// ----------------------------------------------------------------------------
// gcf_checker: port-level checks of the 3x3 gray filter
// Watches the pixel and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module gcf_checker (
  input logic       clk,
  input logic       rst,
  input logic       pix_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic [7:0] filtered_pixel,
  input logic       end_of_row,
  input logic       end_of_image,
  input logic       last_of_run
);

  // stalled result transaction holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(filtered_pixel)
      && $stable(end_of_row) && $stable(end_of_image) && $stable(last_of_run))
    else $error("result changed while stalled");

  // last pixel of the image closes its row and its run
  a_eoi_tags: assert property (@(posedge clk) disable iff (rst)
    res_valid && end_of_image |-> end_of_row && last_of_run)
    else $error("end_of_image without end_of_row and last_of_run");

  // queue empties on reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // no credits are out after reset, so pixels are taken at once
  a_rst_ready: assert property (@(posedge clk) rst |=> !pix_stall)
    else $error("pixel channel stalled right after reset");

endmodule

bind gray_conv3x3_filter gcf_checker u_gcf_checker (
  .clk            (clk),
  .rst            (rst),
  .pix_stall      (pix_stall),
  .res_valid      (res_valid),
  .res_stall      (res_stall),
  .filtered_pixel (filtered_pixel),
  .end_of_row     (end_of_row),
  .end_of_image   (end_of_image),
  .last_of_run    (last_of_run)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for gray_conv3x3_filter
// Streams RGB pixels into the filter with random gaps and output stalls,
// runs a local 3x3 convolution model on every accepted pixel transaction
// and compares each result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;
  import gcf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 38;   // gap / stall rate, percent
  localparam int SETTLE      = 20;   // cycles to let the pipeline empty
  localparam int HOLD_AT     = 80;   // results seen before the long hold
  localparam int HOLD_LEN    = 150;  // cycles of the long output hold
  localparam int RAND_ITEMS  = 230;

  // index past the register list, must be ignored by the block
  localparam logic [2:0] REG_SPARE = 3'd5;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [7:0] pix;
    logic       eor;
    logic       eoi;
    logic       lor;
  } filt_res_t;

  // --------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst       = 1'b1;
  logic              pix_valid = 1'b0;
  logic              pix_stall;
  logic [7:0]        red       = '0;
  logic [7:0]        green     = '0;
  logic [7:0]        blue      = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  logic [7:0]        filtered_pixel;
  logic              end_of_row;
  logic              end_of_image;
  logic              last_of_run;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  gray_conv3x3_filter DUT (
    .clk            (clk),
    .rst            (rst),
    .pix_valid      (pix_valid),
    .pix_stall      (pix_stall),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .filtered_pixel (filtered_pixel),
    .end_of_row     (end_of_row),
    .end_of_image   (end_of_image),
    .last_of_run    (last_of_run),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  rgb_t      pixels_to_send[$];   // filled by the stimulus, drained by the driver
  filt_res_t due_results[$];      // predicted results, oldest first
  int        pix_pushed   = 0;
  int        pix_accepted = 0;
  int        err_count    = 0;
  int        cycle_count  = 0;
  bit        steady       = 1'b0; // no gaps and no random stalls while set

  // --------------------------------------------------------------------------
  // Filter model: configuration copy, line stores, 3x3 window, input position
  // --------------------------------------------------------------------------
  logic [35:0] krow [3];          // top, middle, bottom kernel rows
  logic [12:0] img_w_reg;
  logic [12:0] img_h_reg;
  logic [7:0]  upper_line  [MAX_WIDTH];
  logic [7:0]  middle_line [MAX_WIDTH];
  int          win [3][3];        // [row][col], col 2 is the newest column
  int          pos_row;
  int          pos_col;

  function automatic void model_reset();
    krow[0]   = '0;
    krow[1]   = 36'h000100000;    // center tap 1.0
    krow[2]   = '0;
    img_w_reg = 13'd640;
    img_h_reg = 13'd480;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int a = 0; a < 3; a++)
      for (int c = 0; c < 3; c++)
        win[a][c] = 0;
    pos_row = 0;
    pos_col = 0;
  endfunction

  // zero acts as one, oversize saturates
  function automatic int clip_size(logic [12:0] v, int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic int tap_coef(int kr, int kc);
    logic [11:0] f;
    f = krow[kr][12*kc +: 12];
    return $signed(f);
  endfunction

  // result for image pixel (r, c) centered on window cell (ar, ac);
  // neighbors off the image take the center value
  function automatic int conv_at(int ar, int ac, int r, int c, int w, int h);
    int ctr, acc, v, rr, cc, wr, wc;
    ctr = win[ar][ac];
    acc = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = r + dr;
        cc = c + dc;
        wr = ar + dr;
        wc = ac + dc;
        v  = ctr;
        if (rr >= 0 && rr < h && cc >= 0 && cc < w && wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2)
          v = win[wr][wc];
        acc += v * tap_coef(dr + 1, dc + 1);
      end
    end
    if (acc < 0) return 0;
    acc = acc >>> 8;
    return (acc > 255) ? 255 : acc;
  endfunction

  // one accepted pixel: update the model and queue the results it completes
  function automatic void filter_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    int        w, h, gv, ir, ic, nr, nc;
    int        rws [2];
    int        cls [2];
    filt_res_t res;
    w  = clip_size(img_w_reg, MAX_WIDTH);
    h  = clip_size(img_h_reg, MAX_HEIGHT);
    gv = (77 * int'(r8) + 151 * int'(g8) + 28 * int'(b8)) >> 8;

    // a size change may have left the position outside the image
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    ir = pos_row;
    ic = pos_col;

    for (int a = 0; a < 3; a++) begin
      win[a][0] = win[a][1];
      win[a][1] = win[a][2];
    end
    win[0][2] = upper_line[ic];
    win[1][2] = middle_line[ic];
    win[2][2] = gv;
    upper_line[ic]  = middle_line[ic];
    middle_line[ic] = 8'(gv);

    // rows and columns whose neighborhood is now complete
    nr = 0;
    nc = 0;
    if (ir >= 1) begin
      rws[nr] = ir - 1;
      nr++;
    end
    if (ir == h - 1) begin
      rws[nr] = ir;
      nr++;
    end
    if (ic >= 1) begin
      cls[nc] = ic - 1;
      nc++;
    end
    if (ic == w - 1) begin
      cls[nc] = ic;
      nc++;
    end

    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        res.pix = 8'(conv_at(rws[i] - ir + 2, cls[j] - ic + 2, rws[i], cls[j], w, h));
        res.eor = (cls[j] == w - 1);
        res.eoi = res.eor && (rws[i] == h - 1);
        res.lor = (i == nr - 1) && (j == nc - 1);
        due_results.push_back(res);
      end
    end

    pos_col = ic + 1;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row = ir + 1;
      if (pos_row >= h) pos_row = 0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Pixel driver: offers the next queued pixel once the previous transaction
  // went through; a stalled pixel stays put
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : pixel_driver
    rgb_t nxt;
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (!pix_valid || !pix_stall) begin
      if (pixels_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = pixels_to_send.pop_front();
        pix_valid <= 1'b1;
        red       <= nxt.r;
        green     <= nxt.g;
        blue      <= nxt.b;
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold once enough results
  // have passed, so the result queue fills and the pixel side backs up
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_receiver
    int seen;
    int hold_left;
    bit hold_done;
    if (rst) begin
      res_stall <= 1'b0;
      seen      = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (res_valid && !res_stall) seen++;
      if (!hold_done && seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each pixel transaction, then check each result
  // transaction against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    filt_res_t got;
    filt_res_t want;
    if (!rst) begin
      if (pix_valid && !pix_stall) begin
        filter_pixel(red, green, blue);
        pix_accepted++;
      end
      if (res_valid && !res_stall) begin
        got = '{filtered_pixel, end_of_row, end_of_image, last_of_run};
        if (due_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: pixel %0d eor %b eoi %b last %b",
                     got.pix, got.eor, got.eoi, got.lor);
        end else begin
          want = due_results.pop_front();
          if (got.pix !== want.pix || got.eor !== want.eor ||
              got.eoi !== want.eoi || got.lor !== want.lor) begin
            err_count++;
            if (err_count <= 10)
              $display("result mismatch: expected pixel %0d eor %b eoi %b last %b, got pixel %0d eor %b eoi %b last %b",
                       want.pix, want.eor, want.eoi, want.lor,
                       got.pix, got.eor, got.eoi, got.lor);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // APB write: setup cycle, access cycle, register takes it on the access edge
  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_KTOP:   krow[0]   = val[35:0];
      REG_KMID:   krow[1]   = val[35:0];
      REG_KBOT:   krow[2]   = val[35:0];
      REG_WIDTH:  img_w_reg = val[12:0];
      REG_HEIGHT: img_h_reg = val[12:0];
      default: ;
    endcase
  endtask

  function automatic void queue_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    pixels_to_send.push_back(rgb_t'{r8, g8, b8});
    pix_pushed++;
  endfunction

  // every pixel taken and every result back; pixels in the first row make
  // no result, so give the pipeline time to settle before touching registers
  task automatic wait_idle();
    while (pix_accepted != pix_pushed || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly small smoothing/sharpening taps, sometimes the register extremes
  function automatic logic [35:0] pick_kernel_row();
    logic [35:0] kv;
    int          sel;
    kv  = '0;
    sel = $urandom_range(9);
    case (sel)
      6:       kv = 36'({$urandom(), $urandom()});
      7:       kv = '0;
      8:       kv = 36'h7FF7FF7FF;
      9:       kv = ($urandom_range(1) != 0) ? 36'hFFFFFFFFF : 36'h800800800;
      default: for (int k = 0; k < 3; k++) kv[12*k +: 12] = 12'($urandom_range(384) - 128);
    endcase
    return kv;
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int  rand_items, phase, w, h, cur_w, row, col, rem, count;
    bit  mid_image;
    rand_items = 0;
    model_reset();
    @(negedge rst);
    @(posedge clk);

    // 1x1 images (zero sizes read as one), strongest positive kernel:
    // color extremes, black stays 0, everything else saturates
    reg_write(REG_KTOP, 64'h7FF7FF7FF);
    reg_write(REG_KMID, 64'h7FF7FF7FF);
    reg_write(REG_KBOT, 64'h7FF7FF7FF);
    reg_write(REG_WIDTH, 64'd0);
    reg_write(REG_HEIGHT, 64'd0);
    reg_write(REG_SPARE, '1);
    @(negedge clk);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd0,   8'd0,   8'd0);
    queue_pixel(8'd255, 8'd0,   8'd0);
    queue_pixel(8'd0,   8'd255, 8'd0);
    queue_pixel(8'd0,   8'd0,   8'd255);
    wait_idle();

    // sharpen kernel, oversize width and height saturate; the first row
    // alone produces nothing
    reg_write(REG_KTOP, 64'h000F00000);
    reg_write(REG_KMID, 64'hF00500F00);
    reg_write(REG_KBOT, 64'h000F00000);
    reg_write(REG_WIDTH, 64'h1FFF);
    reg_write(REG_HEIGHT, 64'h1FFF);
    @(negedge clk);
    for (int i = 0; i < 6; i++)
      queue_pixel(i[0] ? 8'd0 : 8'd255, i[0] ? 8'd0 : 8'd255, i[0] ? 8'd0 : 8'd255);
    wait_idle();

    // shrink to 4x2 mid-image: position wraps to the next row, which is
    // then the last one; checkerboard drives both clamps
    reg_write(REG_WIDTH, 64'd4);
    reg_write(REG_HEIGHT, 64'd2);
    @(negedge clk);
    for (int i = 0; i < 4; i++)
      queue_pixel(i[0] ? 8'd255 : 8'd0, i[0] ? 8'd255 : 8'd0, i[0] ? 8'd255 : 8'd0);
    wait_idle();

    // full width, single row, mixed-sign extreme taps
    reg_write(REG_KTOP, 64'hFFFFFFFFF);
    reg_write(REG_KMID, 64'h0807FF080);
    reg_write(REG_KBOT, 64'h800800800);
    reg_write(REG_WIDTH, 64'd4096);
    reg_write(REG_HEIGHT, 64'd1);
    @(negedge clk);
    for (int i = 0; i < 6; i++)
      queue_pixel(8'(i * 51), 8'(255 - i * 40), 8'(i * 13));
    wait_idle();

    // shrink width past the position: wraps to a fresh image
    reg_write(REG_WIDTH, 64'd3);
    @(negedge clk);
    queue_pixel(8'd10, 8'd200, 8'd30);
    queue_pixel(8'd90, 8'd20,  8'd250);
    queue_pixel(8'd255, 8'd128, 8'd1);
    wait_idle();

    // random images; width only grows at an image start so that no row
    // reads a line store column that was never filled
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      steady    = (phase == 1);
      mid_image = (pos_row != 0 || pos_col != 0);
      cur_w     = clip_size(img_w_reg, MAX_WIDTH);
      reg_write(REG_KTOP, 64'(pick_kernel_row()));
      reg_write(REG_KMID, 64'(pick_kernel_row()));
      reg_write(REG_KBOT, 64'(pick_kernel_row()));
      if (!mid_image || $urandom_range(1) != 0) begin
        if (mid_image)
          w = $urandom_range((cur_w < 12) ? cur_w : 12, 1);
        else
          w = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 2);
        h = $urandom_range(6, 1);
        reg_write(REG_WIDTH, 64'(w));
        reg_write(REG_HEIGHT, 64'(h));
      end
      w = clip_size(img_w_reg, MAX_WIDTH);
      h = clip_size(img_h_reg, MAX_HEIGHT);

      // pixels left in the current image, after any wrap
      col = pos_col;
      row = pos_row;
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;
      rem = w * h - (row * w + col);

      if ($urandom_range(3) == 0)
        count = $urandom_range(w * h, 1);      // stop somewhere inside
      else
        count = rem + (($urandom_range(1) != 0) ? w * h : 0);

      @(negedge clk);
      for (int i = 0; i < count; i++)
        queue_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
      rand_items += count;
      wait_idle();
      phase++;
    end
    steady = 1'b0;

    if (err_count == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/gcf_pkg.sv
design/gcf_ram.sv
design/gcf_conv.sv
design/gray_conv3x3_filter.sv
design/gcf_checker.sv
sim/tb_top.sv
